// ----- src/bitmap_block_allocator_top_assert.svh -----
// assertion macros for the bitmap block allocator top level
// expects clk_i and rst_ni in the scope of each use
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BBA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BBA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bba_pkg.sv -----
// shared constants, codes and controller/datapath interface types
// for the bitmap block allocator; no dependencies
package bba_pkg;

  // device and bitmap geometry
  localparam int unsigned MAX_BLOCKS    = 65536;
  localparam int unsigned BLOCK_BYTES   = 4096;
  localparam int unsigned BITS_PER_BYTE = 8;

  // bitmap memory organization: one 64-bit word per row
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned WORDS     = MAX_BLOCKS / WORD_BITS;
  localparam int unsigned ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BLK_W     = $clog2(MAX_BLOCKS);

  // bitmap disk block index shift (bits held by one bitmap disk block)
  localparam int unsigned MAP_SHIFT = $clog2(BITS_PER_BYTE * BLOCK_BYTES);

  // field widths
  localparam int unsigned NUM_W = 16;
  localparam int unsigned TOT_W = 17;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned IDX_W = 2;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_DATA_START  = 2'd0,
    CFG_BLOCK_TOTAL = 2'd1,
    CFG_MAP_START   = 2'd2
  } bba_cfg_e;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic clr;       // clearing pass, write one zero word
    logic accept;    // latch the incoming request
    logic check;     // range check, read first word
    logic scan;      // examine current word, read the next one
    logic free_wr;   // write back the word with the bit cleared
    logic fail;      // load a rejected result
    logic load_out;  // move the result into the output register
  } bba_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;  // clearing pass at its last word
    logic bad;       // request fails its range check
    logic is_free;   // latched request is a free
    logic found;     // current word has a usable clear bit
    logic at_end;    // current word is the last one in range
  } bba_sts_t;

endpackage

// ----- src/bba_dp.sv -----
// datapath of the bitmap block allocator: config registers, bitmap memory,
// first-fit word search, free counter and output register; uses bba_pkg
module bba_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bba_pkg::bba_cmd_t       cmd_i,
  output bba_pkg::bba_sts_t       sts_o,
  input  logic                    cfg_wr_i,
  input  logic [bba_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [bba_pkg::TOT_W-1:0] cfg_data_i,
  input  logic                    req_type_i,
  input  logic [bba_pkg::NUM_W-1:0] block_number_i,
  output logic [bba_pkg::NUM_W-1:0] granted_block_o,
  output logic [bba_pkg::NUM_W-1:0] map_block_o,
  output logic [bba_pkg::CNT_W-1:0] free_total_o,
  output logic                    status_o
);
  import bba_pkg::*;

  logic [NUM_W-1:0]     data_start_q;
  logic [TOT_W-1:0]     block_total_q;
  logic [NUM_W-1:0]     map_start_q;

  logic                 req_type_q;
  logic [NUM_W-1:0]     blk_q;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [ADDR_W-1:0]    ptr_q, ptr_d;
  logic [ADDR_W-1:0]    clr_ptr_q;

  logic [CNT_W-1:0]     cnt_q;
  logic [NUM_W-1:0]     res_granted_q;
  logic [NUM_W-1:0]     res_mapb_q;
  logic                 res_status_q;

  logic [TOT_W-1:0]     eff_total;
  logic [TOT_W-1:0]     last_idx;
  logic [ADDR_W-1:0]    last_word;
  logic [BIT_W-1:0]     last_bit;
  logic [ADDR_W-1:0]    ds_word;
  logic [BIT_W-1:0]     ds_bit;
  logic [ADDR_W-1:0]    blk_word;
  logic [BIT_W-1:0]     blk_bit;
  logic                 bad_alloc;
  logic                 bad_free;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] pick;
  logic [BIT_W-1:0]     pick_idx;
  logic                 found;
  logic                 at_end;
  logic [NUM_W-1:0]     grant_num;
  logic [NUM_W-1:0]     grant_mapb;
  logic [NUM_W-1:0]     free_mapb;

  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q  <= NUM_W'(1);
      block_total_q <= TOT_W'(65536);
      map_start_q   <= NUM_W'(1);
    end else if (cfg_wr_i) begin
      unique case (cfg_index_i)
        CFG_DATA_START:  data_start_q  <= cfg_data_i[NUM_W-1:0];
        CFG_BLOCK_TOTAL: block_total_q <= cfg_data_i;
        CFG_MAP_START:   map_start_q   <= cfg_data_i[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  // latched request
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_type_q <= req_type_i;
      blk_q      <= block_number_i;
    end
  end

  // scan limits and range checks
  always_comb begin
    eff_total = (block_total_q < TOT_W'(MAX_BLOCKS)) ? block_total_q : TOT_W'(MAX_BLOCKS);
    last_idx  = eff_total - TOT_W'(1);
    last_word = last_idx[BIT_W +: ADDR_W];
    last_bit  = last_idx[BIT_W-1:0];
    ds_word   = data_start_q[BIT_W +: ADDR_W];
    ds_bit    = data_start_q[BIT_W-1:0];
    blk_word  = blk_q[BIT_W +: ADDR_W];
    blk_bit   = blk_q[BIT_W-1:0];
    bad_alloc = (data_start_q == '0) || ({1'b0, data_start_q} >= eff_total);
    bad_free  = (blk_q < data_start_q) || ({1'b0, blk_q} >= eff_total);
  end

  // first clear bit of the current word, bits outside the range count as used
  always_comb begin
    lo_mask  = (ptr_q == ds_word) ? ~({WORD_BITS{1'b1}} << ds_bit) : '0;
    hi_mask  = (ptr_q == last_word) ? (({WORD_BITS{1'b1}} << last_bit) << 1) : '0;
    avail    = ~(rdata_q | lo_mask | hi_mask);
    pick     = avail & (~avail + WORD_BITS'(1));
    found    = |avail;
    at_end   = (ptr_q == last_word);
    pick_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (pick[j]) begin
        pick_idx = pick_idx | BIT_W'(j);
      end
    end
    grant_num  = NUM_W'({ptr_q, pick_idx});
    grant_mapb = map_start_q + NUM_W'(grant_num >> MAP_SHIFT);
    free_mapb  = map_start_q + NUM_W'(blk_q >> MAP_SHIFT);
  end

  // memory port selection
  always_comb begin
    rd_en   = cmd_i.check | cmd_i.scan;
    rd_addr = ptr_q + ADDR_W'(1);
    if (cmd_i.check) begin
      rd_addr = (req_type_q == REQ_FREE) ? blk_word : ds_word;
    end
    wr_en   = 1'b0;
    wr_addr = ptr_q;
    wr_data = rdata_q | pick;
    if (cmd_i.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_ptr_q;
      wr_data = '0;
    end else if (cmd_i.scan && found) begin
      wr_en   = 1'b1;
    end else if (cmd_i.free_wr) begin
      wr_en   = 1'b1;
      wr_data = rdata_q & ~(WORD_BITS'(1) << blk_bit);
    end
    ptr_d = ptr_q;
    if (cmd_i.check) begin
      ptr_d = rd_addr;
    end else if (cmd_i.scan && !found) begin
      ptr_d = ptr_q + ADDR_W'(1);
    end
  end

  // bitmap memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // word pointer
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
  end

  // clearing pass pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_ptr_q <= clr_ptr_q + ADDR_W'(1);
    end
  end

  // free-block counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.scan && found) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end else if (cmd_i.free_wr) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fail) begin
      res_granted_q <= '0;
      res_mapb_q    <= '0;
      res_status_q  <= ST_REJECT;
    end else if (cmd_i.scan && found) begin
      res_granted_q <= grant_num;
      res_mapb_q    <= grant_mapb;
      res_status_q  <= ST_DONE;
    end else if (cmd_i.free_wr) begin
      res_granted_q <= '0;
      res_mapb_q    <= free_mapb;
      res_status_q  <= ST_DONE;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      granted_block_o <= res_granted_q;
      map_block_o     <= res_mapb_q;
      free_total_o    <= cnt_q;
      status_o        <= res_status_q;
    end
  end

  // status to the controller
  always_comb begin
    sts_o.clr_last = (clr_ptr_q == ADDR_W'(WORDS - 1));
    sts_o.bad      = (req_type_q == REQ_FREE) ? bad_free : bad_alloc;
    sts_o.is_free  = (req_type_q == REQ_FREE);
    sts_o.found    = found;
    sts_o.at_end   = at_end;
  end

endmodule

// ----- src/bba_ctrl.sv -----
// controller of the bitmap block allocator: sequences the clearing pass,
// range check, word search, write-back and result handoff; uses bba_pkg
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bba_pkg::bba_sts_t sts_i,
  output bba_pkg::bba_cmd_t cmd_o
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FREE_WR,
    S_POST
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    slot_free = !out_valid_q || !out_stall_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.bad) begin
          cmd_o.fail = 1'b1;
          state_d    = S_POST;
        end else if (sts_i.is_free) begin
          state_d = S_FREE_WR;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.found) begin
          state_d = S_POST;
        end else if (sts_i.at_end) begin
          cmd_o.fail = 1'b1;
          state_d    = S_POST;
        end
      end
      S_FREE_WR: begin
        cmd_o.free_wr = 1'b1;
        state_d       = S_POST;
      end
      S_POST: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/bitmap_block_allocator_top.sv -----
// First-fit bitmap block allocator with a 64-bit-wide bitmap memory. After
// reset the block runs a clearing pass over every bitmap word (one bitmap word
// a cycle) and stalls its input meanwhile; configuration writes are taken at
// any time. A free request passes the range check, the write-back and the
// handoff state before its result is valid. An allocate request passes the
// range check and then examines bitmap words: the search reads one 64-bit
// word per cycle from the single-read-port memory, starting at the word of
// data_start, up to the last word in range. A request that fails its range
// check goes from the check straight to the handoff state. The input is taken
// again in the cycle after a result is loaded; a stalled result holds the
// block in its handoff state until the output register is free.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted. Depends on bba_pkg, bba_ctrl,
// bba_dp and the assertion macro header.
module bitmap_block_allocator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [bba_pkg::NUM_W-1:0] block_number_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bba_pkg::NUM_W-1:0] granted_block_o,
  output logic [bba_pkg::NUM_W-1:0] map_block_o,
  output logic [bba_pkg::CNT_W-1:0] free_total_o,
  output logic                      status_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bba_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [bba_pkg::TOT_W-1:0] cfg_data_i
);
  import bba_pkg::*;

  bba_cmd_t cmd;
  bba_sts_t sts;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bba_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_wr_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .block_number_i  (block_number_i),
    .granted_block_o (granted_block_o),
    .map_block_o     (map_block_o),
    .free_total_o    (free_total_o),
    .status_o        (status_o)
  );

  // checks on request flow and rejected results
  `include "bitmap_block_allocator_top_assert.svh"

  `BBA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted request did not make the block busy")
  `BBA_ASSERT_NOW(a_reject_is_zero, out_valid_o && status_o == ST_REJECT, granted_block_o == '0 && map_block_o == '0, "rejected result carries a block number")
  `BBA_ASSERT_NOW(a_result_after_work, $rose(out_valid_o), $past(in_stall_o), "result appeared without a request in work")

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the first-fit bitmap block allocator: a queued request
// driver, a result monitor and an in-bench bitmap model that predicts every reply
// depends on bba_pkg and the bitmap_block_allocator_top rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  // unused register index, writes to it must be ignored
  localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [NUM_W-1:0] blk;
  } request_t;

  typedef struct packed {
    logic [NUM_W-1:0] granted;
    logic [NUM_W-1:0] map_blk;
    logic [CNT_W-1:0] free_cnt;
    logic             status;
  } reply_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic             req_type_i     = REQ_ALLOC;
  logic [NUM_W-1:0] block_number_i = '0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic [NUM_W-1:0] granted_block_o;
  logic [NUM_W-1:0] map_block_o;
  logic [CNT_W-1:0] free_total_o;
  logic             status_o;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i    = '0;
  logic [TOT_W-1:0] cfg_data_i     = '0;

  bitmap_block_allocator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_block_o(granted_block_o),
    .map_block_o    (map_block_o),
    .free_total_o   (free_total_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // allocator model state and its register copies
  bit               block_used [MAX_BLOCKS];
  logic [CNT_W-1:0] model_free_cnt = '0;
  logic [NUM_W-1:0] cfg_start   = 16'd1;
  logic [TOT_W-1:0] cfg_total   = 17'd65536;
  logic [NUM_W-1:0] cfg_map     = 16'd1;

  request_t request_backlog[$];
  reply_t   awaited_replies[$];
  request_t next_req;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned accepted_words = 0;
  int unsigned grants = 0, releases = 0, rejects = 0, settings_used = 0;
  int unsigned errors = 0;
  bit          draining = 1'b0;

  // bitmap disk block that holds the bit of block n
  function automatic logic [NUM_W-1:0] map_block_of(input int unsigned n);
    return cfg_map + NUM_W'(n >> MAP_SHIFT);
  endfunction

  // first-fit allocate or free on the model bitmap, queue the reply
  function automatic void serve_request(input logic kind, input logic [NUM_W-1:0] blk);
    int unsigned limit;
    int unsigned i;
    bit          found;
    reply_t      r;
    limit     = (32'(cfg_total) < MAX_BLOCKS) ? 32'(cfg_total) : MAX_BLOCKS;
    found     = 1'b0;
    r.granted = '0;
    r.map_blk = '0;
    r.status  = ST_REJECT;
    if (kind == REQ_ALLOC) begin
      if (cfg_start != 0 && cfg_start < limit) begin
        for (i = 32'(cfg_start); i < limit && !found; i++) begin
          if (!block_used[NUM_W'(i)]) begin
            found                = 1'b1;
            block_used[NUM_W'(i)] = 1'b1;
            model_free_cnt       = model_free_cnt - 1;
            r.granted            = NUM_W'(i);
            r.map_blk            = map_block_of(i);
            r.status             = ST_DONE;
          end
        end
      end
      if (found) grants++;
      else rejects++;
    end else if (blk >= cfg_start && blk < limit) begin
      // freeing an already free block still counts it
      block_used[blk] = 1'b0;
      model_free_cnt  = model_free_cnt + 1;
      r.map_blk       = map_block_of(32'(blk));
      r.status        = ST_DONE;
      releases++;
    end else begin
      rejects++;
    end
    r.free_cnt = model_free_cnt;
    awaited_replies.push_back(r);
  endfunction

  task automatic report(input string what, input logic [CNT_W-1:0] got,
                        input logic [CNT_W-1:0] want);
    errors++;
    if (errors <= 200)
      $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
  endtask

  // request driver: pops a word when the port is free, predicts on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        serve_request(req_type_i, block_number_i);
        accepted_words++;
        if (accepted_words % 97 == 0) draining = 1'b1;
      end
      if (draining && awaited_replies.size() == 0) draining = 1'b0;
      if (!in_valid_i || !in_stall_o) begin
        if (request_backlog.size() != 0 && !draining &&
            $urandom_range(99) >= send_idle_pct) begin
          next_req = request_backlog.pop_front();
          in_valid_i     <= 1'b1;
          req_type_i     <= next_req.kind;
          block_number_i <= next_req.blk;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  reply_t seen_want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_replies.size() == 0) begin
          report("unexpected result, granted_block", CNT_W'(granted_block_o), '0);
        end else begin
          seen_want = awaited_replies.pop_front();
          if (granted_block_o !== seen_want.granted)
            report("granted_block", CNT_W'(granted_block_o), CNT_W'(seen_want.granted));
          if (map_block_o !== seen_want.map_blk)
            report("map_block", CNT_W'(map_block_o), CNT_W'(seen_want.map_blk));
          if (free_total_o !== seen_want.free_cnt)
            report("free_total", free_total_o, seen_want.free_cnt);
          if (status_o !== seen_want.status)
            report("status", CNT_W'(status_o), CNT_W'(seen_want.status));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic queue_request(input logic kind, input int unsigned blk);
    request_t q;
    q.kind = kind;
    q.blk  = NUM_W'(blk);
    request_backlog.push_back(q);
  endtask

  // register write over the config channel, model updated on the handshake
  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= TOT_W'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DATA_START:  cfg_start = NUM_W'(data);
      CFG_BLOCK_TOTAL: cfg_total = TOT_W'(data);
      CFG_MAP_START:   cfg_map   = NUM_W'(data);
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every request is in and answered, then let the block settle
  task automatic settle();
    do @(negedge clk_i);
    while (request_backlog.size() != 0 || in_valid_i || awaited_replies.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  // free target: mostly near the start of the data range, some anywhere or at the edges
  function automatic int unsigned pick_free_block(input int unsigned lo, input int unsigned hi);
    int unsigned span;
    int unsigned r;
    span = (hi > lo) ? hi - lo : 1;
    if (span > 200) span = 200;
    r = $urandom_range(99);
    if (r < 60) return lo + $urandom_range(span - 1);
    if (r < 80) return $urandom_range(65535);
    case ($urandom_range(3))
      0:       return lo - 1;
      1:       return lo;
      2:       return hi - 1;
      default: return hi;
    endcase
  endfunction

  initial begin
    int unsigned ds, tot, ms;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: grants, double free, an out of range free, upper bitmap block
    settings_used = 1;
    queue_request(REQ_ALLOC, 16'hFFFF);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 1);
    queue_request(REQ_FREE, 1);
    queue_request(REQ_ALLOC, 16'h5555);
    queue_request(REQ_FREE, 0);
    queue_request(REQ_FREE, 65535);
    queue_request(REQ_FREE, 16'hAAAA);
    queue_request(REQ_ALLOC, 0);
    settle();

    // zero data start: allocate refused, block zero still freeable
    write_reg(CFG_DATA_START, 0);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 0);
    settle();

    // top block only, oversized total saturates, bitmap block number wraps
    write_reg(CFG_DATA_START, 17'h1FFFF);
    write_reg(CFG_BLOCK_TOTAL, 17'h1FFFF);
    write_reg(CFG_MAP_START, 65535);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 65534);
    queue_request(REQ_FREE, 65535);
    settle();

    // empty device, then a tiny one that fills up; spare index has no effect
    write_reg(CFG_DATA_START, 3);
    write_reg(CFG_BLOCK_TOTAL, 0);
    write_reg(CFG_MAP_START, 0);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 3);
    settle();
    write_reg(CFG_BLOCK_TOTAL, 5);
    write_reg(CFG_SPARE, 17'h1FFFF);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 5);
    queue_request(REQ_FREE, 4);
    settings_used += 4;

    // random phases, each with its own settings and one of four idling patterns
    for (int k = 0; k < 6; k++) begin
      settle();
      case (k)
        0: begin
          ds = 1 + $urandom_range(15); tot = MAX_BLOCKS; ms = $urandom_range(65535);
        end
        1: begin
          ds = 1 + $urandom_range(100); tot = ds + 40 + $urandom_range(50);
          ms = $urandom_range(65535);
        end
        2: begin
          ds = 32700 + $urandom_range(60); tot = ds + 60 + $urandom_range(80);
          ms = 65535 - $urandom_range(1);
        end
        3: begin
          ds = 1 + $urandom_range(300); tot = 65536 + $urandom_range(65535);
          ms = $urandom_range(65535);
        end
        4: begin
          ds = 1 + $urandom_range(20); tot = ds + 20 + $urandom_range(30); ms = 0;
        end
        default: begin
          ds = 65400 + $urandom_range(100); tot = MAX_BLOCKS; ms = $urandom_range(65535);
        end
      endcase
      write_reg(CFG_DATA_START, ds);
      write_reg(CFG_BLOCK_TOTAL, tot);
      write_reg(CFG_MAP_START, ms);
      settings_used++;
      case (k % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (tot > MAX_BLOCKS) tot = MAX_BLOCKS;
      for (int n = 0; n < 190; n++) begin
        if ($urandom_range(99) < 52) queue_request(REQ_ALLOC, $urandom_range(65535));
        else queue_request(REQ_FREE, pick_free_block(ds, tot));
      end
    end
    settle();
    repeat (20) @(posedge clk_i);

    $display("ran %0d requests over %0d register settings: %0d grants, %0d frees, %0d rejected",
             accepted_words, settings_used, grants, releases, rejects);
    $display("covered full maps, bad starts, out of range and repeated frees, map block wrap");
    if (errors == 0) begin
      $display("bitmap_block_allocator_top: match");
    end else begin
      $display("bitmap_block_allocator_top: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(50_000_000);
    $display("bitmap_block_allocator_top: mismatch");
    $finish;
  end

endmodule
